/* src/cst_pkg.sv */
package cst_pkg;

    // Fixed port widths
    localparam int CMD_W       = 3;
    localparam int IO_WORD_W   = 32;
    localparam int COUNT_OUT_W = 6;
    localparam int MAX_WORD_W  = 64;

    // Command codes; the two unused codes act as query
    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_READ,
        S_LOAD
    } t_state;

endpackage

/* src/cst_ram.sv */
module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cst_ctrl.sv */
module cst_ctrl #(
    parameter int CAPACITY_ENTRIES = 32,
    parameter int WORD_WIDTH       = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [cst_pkg::CMD_W-1:0]             i_cmd,
    input  logic [cst_pkg::IO_WORD_W-1:0]         i_entry_value,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cst_pkg::IO_WORD_W-1:0]         o_current_value,
    output logic                                  o_has_current,
    output logic [cst_pkg::COUNT_OUT_W-1:0]       o_entry_count,
    output logic                                  o_error_flag,
    // item store port
    output logic                                  o_ram_we,
    output logic [$clog2(CAPACITY_ENTRIES)-1:0]   o_ram_waddr,
    output logic [WORD_WIDTH-1:0]                 o_ram_wdata,
    output logic                                  o_ram_re,
    output logic [$clog2(CAPACITY_ENTRIES)-1:0]   o_ram_raddr,
    input  logic [WORD_WIDTH-1:0]                 i_ram_rdata
);

    import cst_pkg::*;

    localparam int AW = $clog2(CAPACITY_ENTRIES);
    localparam int CW = $clog2(CAPACITY_ENTRIES + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_ENTRIES);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_cursor, n_cursor;
    logic [CW-1:0]       r_left, n_left;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    logic [AW-1:0]       r_pos, n_pos;
    logic                r_wr_pend, n_wr_pend;
    logic                r_shift_up, n_shift_up;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic                r_err, n_err;

    logic                r_out_valid, n_out_valid;
    logic [IO_WORD_W-1:0] r_out_value, n_out_value;
    logic                r_out_has, n_out_has;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                r_out_err, n_out_err;

    logic                w_accept;
    logic                w_cur_valid;
    logic                w_full;
    logic [CW-1:0]       w_cnt_m1;
    logic [CW-1:0]       w_cur_p1;
    logic [CW-1:0]       w_new_pos;
    logic [MAX_WORD_W-1:0] w_in_ext;
    logic [MAX_WORD_W-1:0] w_rd_ext;
    logic [CW+COUNT_OUT_W-1:0] w_cnt_ext;

    // Input taken only between commands
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Cursor bookkeeping
    assign w_cur_valid = (r_cursor < r_count);
    assign w_full      = (r_count >= CAP_C);
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_cur_p1    = r_cursor + CW'(1);
    assign w_in_ext    = MAX_WORD_W'(i_entry_value);
    assign w_rd_ext    = MAX_WORD_W'(i_ram_rdata);
    assign w_cnt_ext   = (CW + COUNT_OUT_W)'(r_count);

    always_comb begin
        w_new_pos = '0;
        if (i_cmd == CMD_INSERT) begin
            w_new_pos = w_cur_valid ? r_cursor : '0;
        end else begin
            w_new_pos = w_cur_valid ? w_cur_p1 : r_count;
        end
    end

    // Sequencer: decode, shift loop, new-word write, readback, result load
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_left      = r_left;
        n_ptr       = r_ptr;
        n_wr_addr   = r_wr_addr;
        n_pos       = r_pos;
        n_wr_pend   = r_wr_pend;
        n_shift_up  = r_shift_up;
        n_word      = r_word;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_has   = r_out_has;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr_addr;
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_ptr;

        // downstream took the pending beat
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_err     = 1'b0;
                    n_wr_pend = 1'b0;
                    n_state   = S_READ;
                    case (i_cmd)
                        CMD_START: begin
                            n_cursor = '0;
                        end
                        CMD_ADVANCE: begin
                            if (w_cur_valid) begin
                                n_cursor = w_cur_p1;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        CMD_INSERT, CMD_ATTACH: begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                n_pos      = w_new_pos[AW-1:0];
                                n_left     = r_count - w_new_pos;
                                n_ptr      = w_cnt_m1[AW-1:0];
                                n_shift_up = 1'b1;
                                n_word     = w_in_ext[WORD_WIDTH-1:0];
                                n_count    = r_count + CW'(1);
                                n_cursor   = w_new_pos;
                                n_state    = S_SHIFT;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!w_cur_valid) begin
                                n_err = 1'b1;
                            end else begin
                                n_left     = r_count - w_cur_p1;
                                n_ptr      = w_cur_p1[AW-1:0];
                                n_shift_up = 1'b0;
                                n_count    = w_cnt_m1;
                                n_state    = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // write back the word read last cycle, one place over
                o_ram_we    = r_wr_pend;
                o_ram_waddr = r_wr_addr;
                o_ram_wdata = i_ram_rdata;
                if (r_left != '0) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_ptr;
                    n_wr_pend   = 1'b1;
                    n_wr_addr   = r_shift_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                    n_ptr       = r_shift_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                    n_left      = r_left - CW'(1);
                end else begin
                    n_wr_pend = 1'b0;
                    n_state   = r_shift_up ? S_WRITE : S_READ;
                end
            end
            S_WRITE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos;
                o_ram_wdata = r_word;
                n_state     = S_READ;
            end
            S_READ: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_cursor[AW-1:0];
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                // read data holds until the result register frees up
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_has   = w_cur_valid;
                    n_out_value = w_cur_valid ? w_rd_ext[IO_WORD_W-1:0] : '0;
                    n_out_count = w_cnt_ext[COUNT_OUT_W-1:0];
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_ptr       <= n_ptr;
        r_wr_addr   <= n_wr_addr;
        r_pos       <= n_pos;
        r_shift_up  <= n_shift_up;
        r_word      <= n_word;
        r_err       <= n_err;
        r_out_value <= n_out_value;
        r_out_has   <= n_out_has;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_value = r_out_value;
    assign o_has_current   = r_out_has;
    assign o_entry_count   = r_out_count;
    assign o_error_flag    = r_out_err;

    // Count stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // Cursor never passes the end of the table
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond entry count");

    // A refused insert or attach on a full table leaves count and cursor alone
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_INSERT || i_cmd == CMD_ATTACH) && w_full)
        |=> ($stable(r_count) && $stable(r_cursor) && r_err))
        else $error("full table modified");

    // The store is written only while a command is in progress
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ram_we)
        else $error("store write while idle");

    // A pending shift write only exists inside the shift loop
    a_pend_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (r_state == S_SHIFT))
        else $error("shift write pending outside shift loop");

endmodule

/* src/cursor_sequence_table.sv */
// Channel   Direction  Handshake               Fields
// command   in         i_in_valid/o_in_stall   i_cmd, i_entry_value
// result    out        o_out_valid/i_out_stall o_current_value, o_has_current,
//                                              o_entry_count, o_error_flag
//
// Start, advance, query and refused commands run readback and result load.
// Insert and attach also run the shift loop and new-word write, remove the
// shift loop; the moves run one store read and one store write per cycle.
// Synchronous active-low reset empties the table and puts the cursor at 0;
// the store itself is not cleared.
// A finished result waits in the output register while the next command runs;
// the block holds the end of a command until a stalled result is taken.
module cursor_sequence_table #(
    parameter int CAPACITY_ENTRIES = 32,
    parameter int WORD_WIDTH       = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cst_pkg::CMD_W-1:0]         i_cmd,
    input  logic [cst_pkg::IO_WORD_W-1:0]     i_entry_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cst_pkg::IO_WORD_W-1:0]     o_current_value,
    output logic                              o_has_current,
    output logic [cst_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic                              o_error_flag
);

    import cst_pkg::*;

    localparam int AW = $clog2(CAPACITY_ENTRIES);

    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [WORD_WIDTH-1:0] w_ram_wdata;
    logic                  w_ram_re;
    logic [AW-1:0]         w_ram_raddr;
    logic [WORD_WIDTH-1:0] w_ram_rdata;

    // Command sequencer and result register
    cst_ctrl #(
        .CAPACITY_ENTRIES (CAPACITY_ENTRIES),
        .WORD_WIDTH       (WORD_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_entry_value   (i_entry_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_value (o_current_value),
        .o_has_current   (o_has_current),
        .o_entry_count   (o_entry_count),
        .o_error_flag    (o_error_flag),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_re        (w_ram_re),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata)
    );

    // Item store
    cst_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
